// ----- src/lru_key_value_cache_assert.svh -----
// Assertion macros for the lru_key_value_cache RTL.
`ifndef LRU_KEY_VALUE_CACHE_ASSERT_SVH
`define LRU_KEY_VALUE_CACHE_ASSERT_SVH

`ifndef SYNTHESIS

// Check prop at every clock edge outside reset.
`define LKV_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("lru_key_value_cache: assertion failed");

// Check prop only once the previous edge was outside reset too.
`define LKV_ASSERT_STEADY(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) $past(rst_n) |-> (prop)) \
    else $error("lru_key_value_cache: assertion failed");

`else

`define LKV_ASSERT(label, clk, rst_n, prop)
`define LKV_ASSERT_STEADY(label, clk, rst_n, prop)

`endif

`endif

// ----- src/lkv_pkg.sv -----
// Types, constants and helpers for the LRU key-value cache.
package lkv_pkg;

  localparam int ENTRIES    = 16;
  localparam int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int OCC_W      = $clog2(ENTRIES + 1);
  localparam int CAP_W      = 5;
  localparam int DATA_W     = 32;
  localparam int CFG_ADDR_W = 3;

  localparam logic ACT_GET = 1'b0;
  localparam logic ACT_PUT = 1'b1;

  localparam logic REG_CAPACITY = 1'b0;

  localparam logic [CAP_W-1:0]  CAPACITY_RESET = CAP_W'(16);
  localparam logic [DATA_W-1:0] MISS_VALUE     = '1;

  typedef struct packed {
    logic               action;
    logic signed [31:0] key;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic               hit;
    logic signed [31:0] read_value;
  } out_item_t;

  // Clamp the capacity register to 1 .. ENTRIES.
  function automatic logic [OCC_W-1:0] eff_capacity(input logic [CAP_W-1:0] cap);
    logic [OCC_W-1:0] c;
    if (cap == '0) begin
      c = OCC_W'(1);
    end else if (int'(cap) > ENTRIES) begin
      c = OCC_W'(ENTRIES);
    end else begin
      c = OCC_W'(cap);
    end
    return c;
  endfunction

endpackage

// ----- src/lru_key_value_cache.sv -----
// Top level of the fully associative LRU key-value cache.
//
//  channel   handshake                        payload                 direction
//  -------   ------------------------------   ---------------------   ---------
//  input     start / busy                     in_item                 in
//  result    out_valid (strobe)               out_item                out
//  config    psel penable pwrite / pready     paddr pwdata / prdata   in / out
//
// One beat is taken per clock; busy is high only while reset is applied.
// A get passes the request register, then the result register: the start edge loads the
// request register, the match and rank update over all 16 entries run from it, and the
// result register takes the answer. A put updates the store and gives no result beat.
// Reset (rst_n low, synchronous) clears valid bits and occupancy and sets capacity to 16.
// The receiver cannot stall: out_valid is a one-cycle strobe.
module lru_key_value_cache (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  lkv_pkg::in_item_t              in_item,
  output logic                           out_valid,
  output lkv_pkg::out_item_t             out_item,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [lkv_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  logic                      in_valid_r;
  logic                      in_valid_nxt;
  lkv_pkg::in_item_t         in_item_r;
  logic                      out_valid_r;
  logic                      out_valid_nxt;
  lkv_pkg::out_item_t        out_item_r;
  lkv_pkg::out_item_t        resp;
  logic                      resp_valid;
  logic [lkv_pkg::CAP_W-1:0] capacity;

  // Hold off beats only while reset is applied.
  assign busy          = !rst_n;
  assign in_valid_nxt  = start && !busy;
  assign out_valid_nxt = resp_valid;

  lkv_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .capacity (capacity)
  );

  lkv_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .capacity   (capacity),
    .req_valid  (in_valid_r),
    .req        (in_item_r),
    .resp_valid (resp_valid),
    .resp       (resp)
  );

  // Control flags take reset; payload registers just follow.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid_nxt) begin
      in_item_r <= in_item;
    end
    if (out_valid_nxt) begin
      out_item_r <= resp;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// ----- src/lkv_cfg.sv -----
// APB-style register slice holding the capacity register.
module lkv_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [lkv_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  output logic [lkv_pkg::CAP_W-1:0]      capacity
);

  logic [lkv_pkg::CAP_W-1:0] cap_r;
  logic [lkv_pkg::CAP_W-1:0] cap_nxt;
  logic                      reg_idx;
  logic                      wr_beat;

  assign reg_idx = paddr[lkv_pkg::CFG_ADDR_W-1];
  assign wr_beat = psel && penable && pwrite && pready;

  always_comb begin
    cap_nxt = cap_r;
    if (wr_beat && reg_idx == lkv_pkg::REG_CAPACITY) begin
      cap_nxt = pwdata[lkv_pkg::CAP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= lkv_pkg::CAPACITY_RESET;
    end else begin
      cap_r <= cap_nxt;
    end
  end

  assign prdata   = (reg_idx == lkv_pkg::REG_CAPACITY) ?
                    {{(32-lkv_pkg::CAP_W){1'b0}}, cap_r} : '0;
  assign pready   = 1'b1;
  assign capacity = cap_r;

endmodule

// ----- src/lkv_core.sv -----
// Entry store with parallel key match, recency ranks and replacement.
`include "lru_key_value_cache_assert.svh"

module lkv_core (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [lkv_pkg::CAP_W-1:0] capacity,
  input  logic                      req_valid,
  input  lkv_pkg::in_item_t         req,
  output logic                      resp_valid,
  output lkv_pkg::out_item_t        resp
);

  localparam int N = lkv_pkg::ENTRIES;

  logic [lkv_pkg::DATA_W-1:0] key_r   [N];
  logic [lkv_pkg::DATA_W-1:0] val_r   [N];
  logic [lkv_pkg::IDX_W-1:0]  rank_r  [N];
  logic [lkv_pkg::IDX_W-1:0]  rank_nxt[N];
  logic [N-1:0]               valid_r;
  logic [N-1:0]               valid_nxt;
  logic [lkv_pkg::OCC_W-1:0]  occ_r;
  logic [lkv_pkg::OCC_W-1:0]  occ_nxt;

  logic [N-1:0]               match;
  logic [N-1:0]               lru_oh;
  logic [N-1:0]               free_oh;
  logic [N-1:0]               target_oh;
  logic                       hit;
  logic                       full;
  logic                       is_put;
  logic                       update;
  logic [lkv_pkg::IDX_W-1:0]  hit_rank;
  logic [lkv_pkg::DATA_W-1:0] hit_val;
  logic [lkv_pkg::OCC_W-1:0]  last_rank;

  assign is_put    = (req.action == lkv_pkg::ACT_PUT);
  assign full      = (occ_r >= lkv_pkg::eff_capacity(capacity));
  assign last_rank = occ_r - 1'b1;
  // First free slot: lowest clear valid bit.
  assign free_oh   = ~valid_r & (valid_r + 1'b1);

  always_comb begin
    hit_rank = '0;
    hit_val  = '0;
    for (int i = 0; i < N; i++) begin
      match[i]  = valid_r[i] && (key_r[i] == req.key);
      lru_oh[i] = valid_r[i] && ({1'b0, rank_r[i]} == last_rank);
      if (match[i]) begin
        hit_rank = hit_rank | rank_r[i];
        hit_val  = hit_val | val_r[i];
      end
    end
    hit = |match;
  end

  assign target_oh = hit ? match : (full ? lru_oh : free_oh);
  assign update    = req_valid && (hit || is_put);

  // Target becomes most recent; a hit ages the entries ahead of it, a put
  // miss ages every other held entry; a get miss changes nothing.
  always_comb begin
    valid_nxt = valid_r;
    occ_nxt   = occ_r;
    for (int i = 0; i < N; i++) begin
      rank_nxt[i] = rank_r[i];
      if (update) begin
        if (target_oh[i]) begin
          rank_nxt[i] = '0;
        end else if (valid_r[i] && (!hit || rank_r[i] < hit_rank)) begin
          rank_nxt[i] = rank_r[i] + 1'b1;
        end
      end
    end
    if (update && !hit) begin
      valid_nxt = valid_r | target_oh;
      if (!full) begin
        occ_nxt = occ_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      occ_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      occ_r   <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < N; i++) begin
      rank_r[i] <= rank_nxt[i];
      if (update && is_put && target_oh[i]) begin
        key_r[i] <= req.key;
        val_r[i] <= req.value;
      end
    end
  end

  assign resp_valid      = req_valid && !is_put;
  assign resp.hit        = hit;
  assign resp.read_value = hit ? hit_val : lkv_pkg::MISS_VALUE;

  `LKV_ASSERT(a_one_match, clk, rst_n, $onehot0(match))
  `LKV_ASSERT(a_occ_count, clk, rst_n, $countones(valid_r) == occ_r)
  `LKV_ASSERT(a_target_one, clk, rst_n, !(update && is_put) || $onehot(target_oh))
  `LKV_ASSERT_STEADY(a_occ_grow, clk, rst_n,
    occ_r == $past(occ_r) || occ_r == $past(occ_r) + 1'b1)

endmodule

// ----- dv/lru_key_value_cache_checker.sv -----
// Checker for the LRU key-value cache: tracks the store, predicts get results, compares them.
`timescale 1ns / 100ps

module lru_key_value_cache_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic                           busy,
  input  lkv_pkg::in_item_t              in_item,
  input  logic                           out_valid,
  input  lkv_pkg::out_item_t             out_item,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic                           pready,
  input  logic [lkv_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output int                             errors,
  output int                             pending
);
  import lkv_pkg::*;

  logic [DATA_W-1:0] slot_key   [ENTRIES];
  logic [DATA_W-1:0] slot_value [ENTRIES];
  logic              slot_valid [ENTRIES];
  logic [IDX_W-1:0]  slot_rank  [ENTRIES];
  logic [OCC_W-1:0]  fill_count;
  logic [CAP_W-1:0]  capacity_reg;

  out_item_t expected_reads[$];

  // Clamp the register to 1 .. ENTRIES.
  function automatic logic [OCC_W-1:0] capacity_limit();
    if (capacity_reg == '0) return OCC_W'(1);
    if (int'(capacity_reg) > ENTRIES) return OCC_W'(ENTRIES);
    return OCC_W'(capacity_reg);
  endfunction

  function automatic int find_key(logic [DATA_W-1:0] key);
    for (int i = 0; i < ENTRIES; i++) begin
      if (slot_valid[i] && slot_key[i] == key) return i;
    end
    return -1;
  endfunction

  // Age every entry more recent than the slot, then make the slot most recent.
  task automatic promote(int slot);
    logic [IDX_W-1:0] r;
    r = slot_rank[slot];
    for (int i = 0; i < ENTRIES; i++) begin
      if (slot_valid[i] && i != slot && slot_rank[i] < r) slot_rank[i]++;
    end
    slot_rank[slot] = '0;
  endtask

  task automatic store_put(logic [DATA_W-1:0] key, logic [DATA_W-1:0] value);
    int slot;
    slot = find_key(key);
    if (slot >= 0) begin
      slot_value[slot] = value;
      promote(slot);
    end else if (fill_count >= capacity_limit()) begin
      // Replace the oldest entry in place.
      slot = -1;
      for (int i = 0; i < ENTRIES; i++) begin
        if (slot_valid[i] && (slot < 0 || slot_rank[i] > slot_rank[slot])) slot = i;
      end
      if (slot >= 0) begin
        slot_key[slot]   = key;
        slot_value[slot] = value;
        promote(slot);
      end
    end else begin
      slot = -1;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
        if (!slot_valid[i]) slot = i;
      end
      if (slot >= 0) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (slot_valid[i]) slot_rank[i]++;
        end
        slot_key[slot]   = key;
        slot_value[slot] = value;
        slot_valid[slot] = 1'b1;
        slot_rank[slot]  = '0;
        fill_count++;
      end
    end
  endtask

  task automatic store_get(logic [DATA_W-1:0] key, output out_item_t res);
    int slot;
    slot = find_key(key);
    if (slot >= 0) begin
      res.hit        = 1'b1;
      res.read_value = slot_value[slot];
      promote(slot);
    end else begin
      res.hit        = 1'b0;
      res.read_value = MISS_VALUE;
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      for (int i = 0; i < ENTRIES; i++) slot_valid[i] = 1'b0;
      fill_count   = '0;
      capacity_reg = CAPACITY_RESET;
      expected_reads.delete();
    end else begin
      // Result beats come out in request order.
      if (out_valid) begin
        if (expected_reads.size() == 0) begin
          $error("result beat with no get outstanding: hit %0b read_value %0h",
                 out_item.hit, out_item.read_value);
          errors++;
        end else begin
          want = expected_reads.pop_front();
          if (out_item.hit !== want.hit) begin
            $error("hit: expected %0b actual %0b", want.hit, out_item.hit);
            errors++;
          end
          if (out_item.read_value !== want.read_value) begin
            $error("read_value: expected %0h actual %0h", want.read_value,
                   out_item.read_value);
            errors++;
          end
        end
      end
      if (psel && penable && pwrite && pready) begin
        if ((int'(paddr) >> 2) == int'(REG_CAPACITY)) capacity_reg = pwdata[CAP_W-1:0];
      end
      if (start && !busy) begin
        if (in_item.action == ACT_PUT) begin
          store_put(in_item.key, in_item.value);
        end else begin
          store_get(in_item.key, want);
          expected_reads.push_back(want);
        end
      end
    end
    pending = expected_reads.size();
  end

endmodule

// ----- dv/testbench.sv -----
// Top of the LRU key-value cache testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module testbench;
  import lkv_pkg::*;

  // Address index of a register slot that does not exist.
  localparam int REG_UNUSED  = 1;
  localparam int CYCLE_LIMIT = 400000;
  localparam int POOL_MAX    = 24;

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  in_item_t              in_item;
  logic                  out_valid;
  out_item_t             out_item;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [31:0]           pwdata;
  logic [31:0]           prdata;
  logic                  pready;

  int errors;
  int pending;
  int cycle_count;

  logic [DATA_W-1:0] key_pool [POOL_MAX];
  int                pool_size;

  lru_key_value_cache dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  lru_key_value_cache_checker checker_inst (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .pready    (pready),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .errors    (errors),
    .pending   (pending)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Bail out if the run hangs, e.g. a get whose result beat never shows.
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("lru_key_value_cache test failed");
      $finish;
    end
  end

  // Mostly plain random words, now and then one of the corner values.
  function automatic logic [DATA_W-1:0] pick_word();
    if ($urandom_range(0, 15) == 0) begin
      case ($urandom_range(0, 3))
        0:       return 32'h8000_0000;
        1:       return 32'h7fff_ffff;
        2:       return 32'h0000_0000;
        default: return 32'hffff_ffff;
      endcase
    end
    return $urandom();
  endfunction

  // Present one beat from a falling edge and hold it until taken. Return on the
  // falling edge after acceptance with start still high, so back-to-back beats
  // never drop start.
  task automatic send_item(logic act, logic [DATA_W-1:0] key, logic [DATA_W-1:0] value);
    in_item.action = act;
    in_item.key    = key;
    in_item.value  = value;
    start          = 1'b1;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  task automatic hold_off(int cycles);
    start = 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  // Stop sending and wait until every get has its result beat, then let the
  // pipeline drain any trailing put.
  task automatic wait_for_reads();
    start = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Setup cycle, then access cycle held until pready.
  task automatic cfg_write(int index, logic [31:0] data);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = CFG_ADDR_W'(index * 4);
    pwdata  = data;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // Set capacity while idle; upper data bits carry noise the register drops.
  task automatic set_capacity(logic [CAP_W-1:0] cap);
    wait_for_reads();
    cfg_write(int'(REG_CAPACITY), ($urandom() & ~32'h1f) | 32'(cap));
  endtask

  // Run a phase of traffic over a key pool sized around the capacity, so hits,
  // updates and evictions all happen. A few beats use fresh random keys.
  task automatic run_phase(logic [CAP_W-1:0] cap, int count, bit gaps, bit mid_drain);
    int limit;
    logic [DATA_W-1:0] key;
    limit = (cap == 0) ? 1 : (int'(cap) > ENTRIES ? ENTRIES : int'(cap));
    pool_size = limit + $urandom_range(0, 5);
    if (pool_size < 2) pool_size = 2;
    if (pool_size > POOL_MAX) pool_size = POOL_MAX;
    for (int i = 0; i < pool_size; i++) key_pool[i] = pick_word();
    for (int n = 0; n < count; n++) begin
      if (gaps && $urandom_range(0, 7) == 0) hold_off($urandom_range(1, 19));
      if (mid_drain && n == count / 2) wait_for_reads();
      if ($urandom_range(0, 9) == 0) key = pick_word();
      else key = key_pool[$urandom_range(0, pool_size - 1)];
      send_item(($urandom_range(0, 99) < 45) ? ACT_PUT : ACT_GET, key, pick_word());
    end
  endtask

  initial begin
    rst_n   = 1'b0;
    start   = 1'b0;
    in_item = '0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed: miss on an empty store, corner keys and values, update on hit.
    send_item(ACT_GET, 32'h0000_0000, 32'h1111_1111);
    send_item(ACT_PUT, 32'h8000_0000, 32'h7fff_ffff);
    send_item(ACT_PUT, 32'h7fff_ffff, 32'h8000_0000);
    send_item(ACT_PUT, 32'h0000_0000, 32'h0000_0000);
    send_item(ACT_PUT, 32'hffff_ffff, 32'hffff_ffff);
    send_item(ACT_GET, 32'h8000_0000, 32'h0000_0000);
    send_item(ACT_GET, 32'h7fff_ffff, 32'hffff_ffff);
    send_item(ACT_PUT, 32'hffff_ffff, 32'h5a5a_5a5a);
    send_item(ACT_GET, 32'hffff_ffff, 32'ha5a5_a5a5);
    send_item(ACT_GET, 32'h0000_0001, 32'h0000_0000);

    // Lower capacity under the four held entries: a miss replaces just the oldest.
    set_capacity(CAP_W'(1));
    send_item(ACT_PUT, 32'h0000_0007, 32'h0000_0070);
    send_item(ACT_GET, 32'h0000_0000, 32'h0000_0000);
    send_item(ACT_GET, 32'h0000_0007, 32'h0000_0000);

    // Zero capacity acts as one.
    set_capacity(CAP_W'(0));
    send_item(ACT_PUT, 32'h0000_0008, 32'h0000_0080);
    send_item(ACT_GET, 32'h0000_0008, 32'h0000_0000);
    send_item(ACT_GET, 32'h8000_0000, 32'h0000_0000);

    // Write to a missing register: drop it, capacity must stay at zero.
    wait_for_reads();
    cfg_write(REG_UNUSED, 32'h0000_0010);
    send_item(ACT_PUT, 32'h0000_0009, 32'h0000_0090);
    send_item(ACT_GET, 32'h0000_0008, 32'h0000_0000);
    send_item(ACT_GET, 32'h0000_0009, 32'h0000_0000);

    // Random phases across capacity settings; entries carry over between them.
    run_phase(CAP_W'(31), 140, 1'b1, 1'b0);
    set_capacity(CAP_W'(1));
    run_phase(CAP_W'(1), 120, 1'b1, 1'b0);
    set_capacity(CAP_W'(0));
    run_phase(CAP_W'(0), 100, 1'b1, 1'b0);
    set_capacity(CAP_W'(17));
    run_phase(CAP_W'(17), 150, 1'b1, 1'b1);
    set_capacity(CAP_W'(5));
    run_phase(CAP_W'(5), 140, 1'b1, 1'b0);
    set_capacity(CAP_W'(16));
    run_phase(CAP_W'(16), 160, 1'b1, 1'b0);
    set_capacity(CAP_W'(2));
    run_phase(CAP_W'(2), 120, 1'b1, 1'b0);
    set_capacity(CAP_W'(31));
    run_phase(CAP_W'(31), 140, 1'b1, 1'b0);
    for (int p = 0; p < 2; p++) begin
      set_capacity(CAP_W'($urandom_range(1, 16)));
      run_phase(CAP_W'(8), 120, 1'b1, 1'b0);
    end
    // Last stretch runs back to back with no idling.
    set_capacity(CAP_W'(16));
    run_phase(CAP_W'(16), 200, 1'b0, 1'b0);

    // Let every outstanding result beat land before the verdict.
    wait_for_reads();
    repeat (8) @(negedge clk);
    if (errors == 0) begin
      $display("lru_key_value_cache test passed");
    end else begin
      $display("lru_key_value_cache test failed");
    end
    $finish;
  end

endmodule

// ----- lru_key_value_cache.f -----
+incdir+src
src/lkv_pkg.sv
src/lkv_cfg.sv
src/lkv_core.sv
src/lru_key_value_cache.sv
dv/lru_key_value_cache_checker.sv
dv/testbench.sv
